>>> hw/rtl/mfh_pkg.sv
// Shared types and constants for the mutex lock with a waiting-thread queue.
package mfh_pkg;

  localparam int TID_W        = 4;
  localparam int THREAD_COUNT = 16;
  localparam int STATUS_W     = 3;
  localparam int WCOUNT_W     = 5;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_IGNORE  = 2'd2
  } cmd_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED = 3'd0,
    ST_ALREADY = 3'd1,
    ST_QUEUED  = 3'd2,
    ST_FREED   = 3'd3,
    ST_HANDOFF = 3'd4,
    ST_IGNORED = 3'd5,
    ST_FULL    = 3'd6
  } status_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [TID_W-1:0]   tid;
  } cmd_t;

  typedef struct packed {
    status_t               status;
    logic                  wake_valid;
    logic [TID_W-1:0]      wake_thread;
    logic                  lock_held;
    logic [TID_W-1:0]      lock_owner;
    logic                  caller_holds;
    logic [WCOUNT_W-1:0]   waiter_count;
  } res_t;

endpackage

>>> hw/rtl/mfh_front.sv
// Request intake: classifies each request and holds it in a two-entry command queue.
module mfh_front
  import mfh_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic             in_opcode,
  input  logic [TID_W-1:0] in_thread_id,
  output logic             cmd_valid,
  output cmd_t             cmd,
  input  logic             cmd_take
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       new_cmd;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    new_cmd.tid = in_thread_id;
    if ({1'b0, in_thread_id} >= (TID_W+1)'(THREAD_COUNT)) begin
      new_cmd.kind = CMD_IGNORE;
    end else if (in_opcode == OP_RELEASE) begin
      new_cmd.kind = CMD_RELEASE;
    end else begin
      new_cmd.kind = CMD_ACQUIRE;
    end
  end

  assign full      = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/mfh_back.sv
// Lock unit: owner register, waiter memory with its pointers, and the request sequencer.
module mfh_back
  import mfh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_take,
  input  logic res_room,
  output logic res_push,
  output res_t res
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic             owner_valid_r, owner_valid_nxt;
  logic [TID_W-1:0] owner_id_r, owner_id_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TID_W-1:0] waiter_mem [QUEUE_DEPTH];
  logic [TID_W-1:0] rd_data_r;
  logic             mem_wr;
  logic             is_owner;
  status_t          status;
  logic             wake;
  logic [CNT_W+WCOUNT_W-1:0] count_ext;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign is_owner = owner_valid_r && (owner_id_r == cmd_r.tid);

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    owner_valid_nxt = owner_valid_r;
    owner_id_nxt    = owner_id_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    cmd_take        = 1'b0;
    res_push        = 1'b0;
    mem_wr          = 1'b0;
    status          = ST_IGNORED;
    wake            = 1'b0;
    case (cmd_r.kind)
      CMD_ACQUIRE: begin
        if (is_owner) begin
          status = ST_ALREADY;
        end else if (!owner_valid_r) begin
          status = ST_GRANTED;
        end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
          status = ST_FULL;
        end else begin
          status = ST_QUEUED;
        end
      end
      CMD_RELEASE: begin
        if (!is_owner) begin
          status = ST_IGNORED;
        end else if (count_r != '0) begin
          status = ST_HANDOFF;
          wake   = 1'b1;
        end else begin
          status = ST_FREED;
        end
      end
      default: begin
        status = ST_IGNORED;
      end
    endcase
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take  = 1'b1;
          cmd_nxt   = cmd;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (res_room) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
          case (status)
            ST_GRANTED: begin
              owner_valid_nxt = 1'b1;
              owner_id_nxt    = cmd_r.tid;
            end
            ST_QUEUED: begin
              mem_wr    = 1'b1;
              tail_nxt  = next_slot(tail_r);
              count_nxt = count_r + CNT_W'(1);
            end
            ST_HANDOFF: begin
              owner_id_nxt = rd_data_r;
              head_nxt     = next_slot(head_r);
              count_nxt    = count_r - CNT_W'(1);
            end
            ST_FREED: begin
              owner_valid_nxt = 1'b0;
              owner_id_nxt    = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign count_ext = {{WCOUNT_W{1'b0}}, count_nxt};

  always_comb begin
    res.status       = status;
    res.wake_valid   = wake;
    res.wake_thread  = wake ? rd_data_r : '0;
    res.lock_held    = owner_valid_nxt;
    res.lock_owner   = owner_valid_nxt ? owner_id_nxt : '0;
    res.caller_holds = owner_valid_nxt && (owner_id_nxt == cmd_r.tid);
    res.waiter_count = count_ext[WCOUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      waiter_mem[tail_r] <= cmd_r.tid;
    end
    rd_data_r <= waiter_mem[head_r];
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (!rst_n) begin
      state_r       <= S_IDLE;
      owner_valid_r <= 1'b0;
      owner_id_r    <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      owner_valid_r <= owner_valid_nxt;
      owner_id_r    <= owner_id_nxt;
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      count_r       <= count_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("waiter count exceeds the queue depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> owner_valid_r)
    else $error("threads are waiting on a free lock");

  assert property (@(posedge clk) disable iff (!rst_n)
    !owner_valid_r |-> (owner_id_r == '0))
    else $error("free lock carries a stale owner id");

  assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (state_r == S_IDLE) && $stable(cmd_r))
    else $error("sequencer did not return to idle after a result transfer");

endmodule

>>> hw/rtl/mfh_resq.sv
// Result queue: two entries that part the lock unit from the consumer.
module mfh_resq
  import mfh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic res_push,
  input  res_t res,
  output logic res_room,
  output logic empty,
  input  logic pop,
  output res_t head
);

  res_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign res_room = (count_r != 2'd2);
  assign empty    = (count_r == 2'd0);
  assign head     = slot_r[rd_ptr_r];
  assign do_push  = res_push && res_room;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/mutex_fifo_handoff_top.sv
// Top level of the hardware mutex with a first-in first-out queue of waiting threads.
// Requests enter a two-entry command queue, and the lock unit then takes one request at a
// time: while it takes the request, the oldest waiter is fetched from the waiter memory,
// whose read port is registered; then it updates the owner and the queue pointers and
// writes the result, waiting while the result queue has no room. It takes no new request
// until it has written the result of the last one.
// Results wait in a two-entry queue, so the intake keeps taking requests while the consumer
// stalls, until both small queues are full.
module mutex_fifo_handoff_top
  import mfh_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic                in_opcode,
  input  logic [TID_W-1:0]    in_thread_id,
  output logic                empty,
  input  logic                pop,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_wake_valid,
  output logic [TID_W-1:0]    out_wake_thread,
  output logic                out_lock_held,
  output logic [TID_W-1:0]    out_lock_owner,
  output logic                out_caller_holds,
  output logic [WCOUNT_W-1:0] out_waiter_count
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_room;
  logic res_push;
  res_t res;
  res_t head;

  mfh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_opcode    (in_opcode),
    .in_thread_id (in_thread_id),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  mfh_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_room  (res_room),
    .res_push  (res_push),
    .res       (res)
  );

  mfh_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res      (res),
    .res_room (res_room),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign out_status       = head.status;
  assign out_wake_valid   = head.wake_valid;
  assign out_wake_thread  = head.wake_thread;
  assign out_lock_held    = head.lock_held;
  assign out_lock_owner   = head.lock_owner;
  assign out_caller_holds = head.caller_holds;
  assign out_waiter_count = head.waiter_count;

endmodule

>>> tb/mutex_fifo_handoff_top_tb.sv
// Self-checking testbench for the mutex lock with a waiting-thread queue.
`timescale 1ns / 1ps

module mutex_fifo_handoff_top_tb
  import mfh_pkg::*;
();

  localparam int          WAIT_DEPTH     = 16;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          HOLD_OFF       = 150;
  localparam int          PHASE_ITEMS    = 415;

  typedef struct packed {
    logic               op;
    logic [TID_W-1:0]   tid;
    logic               has_want;
    res_t               want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic                in_opcode = 1'b0;
  logic [TID_W-1:0]    in_thread_id = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic                out_wake_valid;
  logic [TID_W-1:0]    out_wake_thread;
  logic                out_lock_held;
  logic [TID_W-1:0]    out_lock_owner;
  logic                out_caller_holds;
  logic [WCOUNT_W-1:0] out_waiter_count;

  logic                lk_held = 1'b0;
  logic [TID_W-1:0]    lk_owner = '0;
  logic [TID_W-1:0]    lk_waiters[$];

  res_t                pending_results[$];
  dir_row_t            dir_table[$];

  int                  idle_pct = 0;
  int                  stall_pct = 0;
  int                  hold_left = 0;
  int                  errors = 0;
  int                  n_sent = 0;
  int                  n_checked = 0;
  int                  status_seen[8];
  int                  quiet_cycles = 0;

  mutex_fifo_handoff_top #(
    .QUEUE_DEPTH(WAIT_DEPTH)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_opcode        (in_opcode),
    .in_thread_id     (in_thread_id),
    .empty            (empty),
    .pop              (pop),
    .out_status       (out_status),
    .out_wake_valid   (out_wake_valid),
    .out_wake_thread  (out_wake_thread),
    .out_lock_held    (out_lock_held),
    .out_lock_owner   (out_lock_owner),
    .out_caller_holds (out_caller_holds),
    .out_waiter_count (out_waiter_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic lock_step(input logic op, input logic [TID_W-1:0] tid, output res_t r);
    logic is_owner;
    is_owner = lk_held && (lk_owner == tid);
    r = '0;
    if (tid >= THREAD_COUNT) begin
      r.status = ST_IGNORED;
    end else if (op == OP_ACQUIRE) begin
      if (is_owner) begin
        r.status = ST_ALREADY;
      end else if (!lk_held) begin
        lk_held  = 1'b1;
        lk_owner = tid;
        r.status = ST_GRANTED;
      end else if (lk_waiters.size() >= WAIT_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        lk_waiters.push_back(tid);
        r.status = ST_QUEUED;
      end
    end else begin
      if (!is_owner) begin
        r.status = ST_IGNORED;
      end else if (lk_waiters.size() > 0) begin
        lk_owner      = lk_waiters.pop_front();
        r.wake_valid  = 1'b1;
        r.wake_thread = lk_owner;
        r.status      = ST_HANDOFF;
      end else begin
        lk_held  = 1'b0;
        lk_owner = '0;
        r.status = ST_FREED;
      end
    end
    r.lock_held    = lk_held;
    r.lock_owner   = lk_held ? lk_owner : '0;
    r.caller_holds = lk_held && (lk_owner == tid);
    r.waiter_count = WCOUNT_W'(lk_waiters.size());
  endtask

  // Drives one request and returns once its transfer has taken place.
  task automatic issue(input logic op, input logic [TID_W-1:0] tid, input logic has_want,
                       input res_t want);
    res_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    in_opcode    <= op;
    in_thread_id <= tid;
    @(posedge clk);
    while (full) @(posedge clk);
    lock_step(op, tid, r);
    pending_results.push_back(has_want ? want : r);
    n_sent++;
  endtask

  function automatic void add_row(logic op, logic [TID_W-1:0] tid, logic has_want,
                                  status_t st, logic held, logic [TID_W-1:0] owner,
                                  logic caller, logic [WCOUNT_W-1:0] cnt);
    dir_row_t row;
    row                   = '0;
    row.op                = op;
    row.tid               = tid;
    row.has_want          = has_want;
    row.want.status       = st;
    row.want.lock_held    = held;
    row.want.lock_owner   = owner;
    row.want.caller_holds = caller;
    row.want.waiter_count = cnt;
    dir_table.push_back(row);
  endfunction

  task automatic run_random(input int n_items);
    int          burst_left;
    int          acq_pct;
    logic        op;
    logic [TID_W-1:0] tid;
    burst_left = 0;
    acq_pct    = 50;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0:       acq_pct = 85;
          1:       acq_pct = 50;
          default: acq_pct = 20;
        endcase
      end
      burst_left--;
      op  = ($urandom_range(0, 99) < acq_pct) ? OP_ACQUIRE : OP_RELEASE;
      tid = TID_W'($urandom_range(0, THREAD_COUNT - 1));
      if (op == OP_RELEASE && lk_held && $urandom_range(0, 99) < 85) tid = lk_owner;
      issue(op, tid, 1'b0, '0);
    end
  endtask

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic take_result();
    res_t want;
    status_seen[out_status]++;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual status %0d", $time, out_status);
    end else begin
      want = pending_results.pop_front();
      cmp_field("status", want.status, out_status);
      cmp_field("wake_valid", want.wake_valid, out_wake_valid);
      cmp_field("wake_thread", want.wake_thread, out_wake_thread);
      cmp_field("lock_held", want.lock_held, out_lock_held);
      cmp_field("lock_owner", want.lock_owner, out_lock_owner);
      cmp_field("caller_holds", want.caller_holds, out_caller_holds);
      cmp_field("waiter_count", want.waiter_count, out_waiter_count);
    end
    n_checked++;
  endtask

  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
      @(posedge clk);
      if (pop && !empty) take_result();
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // Release on a free lock, grant, re-acquire by the owner, free, and a non-owner release.
    add_row(OP_RELEASE, 4'd0,  1'b1, ST_IGNORED, 1'b0, 4'd0,  1'b0, 5'd0);
    add_row(OP_ACQUIRE, 4'd15, 1'b1, ST_GRANTED, 1'b1, 4'd15, 1'b1, 5'd0);
    add_row(OP_ACQUIRE, 4'd15, 1'b1, ST_ALREADY, 1'b1, 4'd15, 1'b1, 5'd0);
    add_row(OP_RELEASE, 4'd15, 1'b1, ST_FREED,   1'b0, 4'd0,  1'b0, 5'd0);
    add_row(OP_ACQUIRE, 4'd0,  1'b1, ST_GRANTED, 1'b1, 4'd0,  1'b1, 5'd0);
    add_row(OP_RELEASE, 4'd15, 1'b1, ST_IGNORED, 1'b1, 4'd0,  1'b0, 5'd0);
    // Fill the wait queue, with one thread queued twice, then overflow it and hand the lock off twice.
    for (int t = 1; t < THREAD_COUNT; t++) begin
      add_row(OP_ACQUIRE, TID_W'(t), 1'b0, ST_QUEUED, 1'b0, 4'd0, 1'b0, 5'd0);
    end
    add_row(OP_ACQUIRE, 4'd1,  1'b0, ST_QUEUED,  1'b0, 4'd0,  1'b0, 5'd0);
    add_row(OP_ACQUIRE, 4'd7,  1'b1, ST_FULL,    1'b1, 4'd0,  1'b0, 5'd16);
    add_row(OP_RELEASE, 4'd0,  1'b0, ST_HANDOFF, 1'b0, 4'd0,  1'b0, 5'd0);
    add_row(OP_RELEASE, 4'd1,  1'b0, ST_HANDOFF, 1'b0, 4'd0,  1'b0, 5'd0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      issue(dir_table[i].op, dir_table[i].tid, dir_table[i].has_want, dir_table[i].want);
    end

    // The consumer holds off while requests keep coming, so both internal queues fill.
    hold_left = HOLD_OFF;
    run_random(30);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 68; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      run_random(PHASE_ITEMS);
    end

    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d results for %0d requests across four idle and stall mixes",
             n_checked, n_sent);
    $display("and one long consumer hold-off; status counts granted %0d already %0d",
             status_seen[ST_GRANTED], status_seen[ST_ALREADY]);
    $display("queued %0d freed %0d handed off %0d ignored %0d full %0d",
             status_seen[ST_QUEUED], status_seen[ST_FREED], status_seen[ST_HANDOFF],
             status_seen[ST_IGNORED], status_seen[ST_FULL]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
